FILE: sv/dnd_pkg.sv
package dnd_pkg;

  // Request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PARSE = 1'b1;

  // Top two bits of a length byte
  localparam logic [1:0] TYPE_LABEL = 2'b00;
  localparam logic [1:0] TYPE_PTR   = 2'b11;

  // Label separator in the dotted text
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Name bytes per result chunk
  localparam logic [3:0] CHUNK_BYTES = 4'd8;

  // Width of the next offset field
  localparam int unsigned NEXT_W = 10;

  // Final status of a parse
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END       = 3'd1,
    ST_TRUNC_PTR = 3'd2,
    ST_PTR_OOB   = 3'd3,
    ST_LOOP      = 3'd4,
    ST_BAD_TYPE  = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

endpackage

FILE: sv/dns_name_decompressor.sv
// Channel | Ports                                          | Moves
// in      | in_valid, in_ready, in_opcode, in_packet_byte, | load byte or parse request
//         | in_packet_end, in_start_offset                 |
// out     | out_valid, out_ready, out_name_chunk,          | name chunks, then last result
//         | out_chunk_bytes, out_last, out_next_offset,    |
//         | out_status                                     |
// A load request writes the packet store directly.
// A parse request holds in_ready low while it walks the store, reading it
// through its single read port; the walk stalls while out_ready is low and
// a chunk or the last result has to wait for the output register.
// A finished result waits in the output register; the walk keeps going until
// a second chunk would need that register. Reset: rst_n, synchronous, low.
module dns_name_decompressor import dnd_pkg::*; #(
  parameter int unsigned PACKET_BYTES   = 512,
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [7:0]        in_packet_byte,
  input  logic              in_packet_end,
  input  logic [8:0]        in_start_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_name_chunk,
  output logic [3:0]        out_chunk_bytes,
  output logic              out_last,
  output logic [NEXT_W-1:0] out_next_offset,
  output logic [2:0]        out_status
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned LW = $clog2(PACKET_BYTES + 1);

  logic          busy;
  logic          in_fire, load_fire, parse_fire;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  logic [LW-1:0] pkt_len;

  // Requests are taken only while no parse is walking, so store writes
  // and walk reads never meet
  assign in_ready   = !busy;
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_opcode == OP_LOAD);
  assign parse_fire = in_fire && (in_opcode == OP_PARSE);

  dnd_loader #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_loader (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_fire  (load_fire),
    .packet_byte(in_packet_byte),
    .packet_end (in_packet_end),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .pkt_len    (pkt_len)
  );

  dnd_store #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  dnd_walker #(
    .PACKET_BYTES  (PACKET_BYTES),
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (parse_fire),
    .start_offset   (in_start_offset),
    .pkt_len        (pkt_len),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_name_chunk (out_name_chunk),
    .out_chunk_bytes(out_chunk_bytes),
    .out_last       (out_last),
    .out_next_offset(out_next_offset),
    .out_status     (out_status)
  );

endmodule

FILE: sv/dnd_store.sv
module dnd_store import dnd_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 512,
  localparam int unsigned AW = $clog2(PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [PACKET_BYTES];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/dnd_loader.sv
module dnd_loader import dnd_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 512,
  localparam int unsigned AW = $clog2(PACKET_BYTES),
  localparam int unsigned LW = $clog2(PACKET_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_fire,
  input  logic [7:0]    packet_byte,
  input  logic          packet_end,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic [LW-1:0] pkt_len
);

  logic [LW-1:0] wpos_r;
  logic [LW-1:0] len_r;
  logic          closed_r;
  logic [LW-1:0] wpos_eff;
  logic          room;

  // A closed packet restarts at position zero
  assign wpos_eff = closed_r ? '0 : wpos_r;
  assign room     = wpos_eff < LW'(PACKET_BYTES);

  assign wr_en   = load_fire && room;
  assign wr_addr = wpos_eff[AW-1:0];
  assign wr_data = packet_byte;
  assign pkt_len = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r   <= '0;
      len_r    <= '0;
      closed_r <= 1'b1;
    end else if (load_fire) begin
      if (room) begin
        wpos_r <= wpos_eff + LW'(1);
        len_r  <= wpos_eff + LW'(1);
      end else if (closed_r) begin
        wpos_r <= '0;
        len_r  <= '0;
      end
      closed_r <= packet_end;
    end
  end

endmodule

FILE: sv/dnd_walker.sv
module dnd_walker import dnd_pkg::*; #(
  parameter int unsigned PACKET_BYTES   = 512,
  parameter int unsigned MAX_NAME_BYTES = 255,
  localparam int unsigned AW   = $clog2(PACKET_BYTES),
  localparam int unsigned LW   = $clog2(PACKET_BYTES + 1),
  localparam int unsigned CW   = (LW > 9) ? LW : 9,
  localparam int unsigned CMPW = ((CW > 14) ? CW : 14) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [8:0]          start_offset,
  input  logic [LW-1:0]       pkt_len,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_name_chunk,
  output logic [3:0]          out_chunk_bytes,
  output logic                out_last,
  output logic [NEXT_W-1:0]   out_next_offset,
  output logic [2:0]          out_status
);

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_TYPE, S_PTR, S_LBL, S_FIN} state_t;

  state_t            state_r;
  logic [CW-1:0]     cur_r;
  logic [5:0]        rem_r;
  logic [5:0]        hi_r;
  logic              jumped_r;
  logic [LW:0]       jumps_r;
  logic [NEXT_W-1:0] next_r;
  logic [7:0]        nlen_r;
  logic [63:0]       chunk_r;
  logic [3:0]        cnt_r;
  status_t           stat_r;

  logic              out_valid_r;
  logic [63:0]       out_chunk_r;
  logic [3:0]        out_bytes_r;
  logic              out_last_r;
  logic [NEXT_W-1:0] out_next_r;
  logic [2:0]        out_status_r;

  logic [CMPW-1:0]   len_x, cur_x, cur1_x, cur2_x, lbl_end_x, ptr_x, jumps_x;
  logic [LW:0]       jumps_inc;
  logic              stall, out_free, name_full, is_ptr, is_label;
  logic              put_en;
  logic [7:0]        put_val;

  // Cursor arithmetic and compares
  assign len_x     = CMPW'(pkt_len);
  assign cur_x     = CMPW'(cur_r);
  assign cur1_x    = cur_x + CMPW'(1);
  assign cur2_x    = cur_x + CMPW'(2);
  assign lbl_end_x = cur1_x + CMPW'(rd_data[5:0]);
  assign ptr_x     = CMPW'({hi_r, rd_data});
  assign jumps_inc = jumps_r + (LW+1)'(1);
  assign jumps_x   = CMPW'(jumps_inc);

  // A full chunk blocks the walk until it moves to the output register
  assign stall     = (cnt_r == CHUNK_BYTES);
  assign out_free  = !out_valid_r || out_ready;
  assign name_full = nlen_r >= 8'(MAX_NAME_BYTES);
  assign is_ptr    = (rd_data[7:6] == TYPE_PTR);
  assign is_label  = (rd_data[7:6] == TYPE_LABEL);

  // Store reads and name byte appends for this cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_r[AW-1:0];
    put_en  = 1'b0;
    put_val = rd_data;
    if (!stall) begin
      unique case (state_r)
        S_HEAD: begin
          rd_en = (cur_x < len_x);
        end
        S_TYPE: begin
          rd_addr = cur1_x[AW-1:0];
          if (is_ptr) begin
            rd_en = (cur1_x < len_x);
          end else if (is_label && rd_data != 8'd0 && lbl_end_x <= len_x &&
                       !(nlen_r != 8'd0 && name_full)) begin
            rd_en   = 1'b1;
            put_en  = (nlen_r != 8'd0);
            put_val = DOT_CHAR;
          end
        end
        S_LBL: begin
          rd_addr = cur1_x[AW-1:0];
          put_en  = !name_full;
          rd_en   = !name_full && (rem_r > 6'd1);
        end
        S_IDLE, S_PTR, S_FIN: ;
        default: ;
      endcase
    end
  end

  // Walk state, chunk assembly and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register: full chunks first, then the last result
      if (stall && out_free) begin
        out_valid_r  <= 1'b1;
        out_chunk_r  <= chunk_r;
        out_bytes_r  <= CHUNK_BYTES;
        out_last_r   <= 1'b0;
        out_next_r   <= '0;
        out_status_r <= ST_OK;
        chunk_r      <= '0;
        cnt_r        <= '0;
      end else if (state_r == S_FIN && out_free) begin
        out_valid_r  <= 1'b1;
        out_chunk_r  <= (stat_r == ST_OK) ? chunk_r : '0;
        out_bytes_r  <= (stat_r == ST_OK) ? cnt_r : '0;
        out_last_r   <= 1'b1;
        out_next_r   <= (stat_r == ST_OK) ? next_r : '0;
        out_status_r <= stat_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Append one name byte
      if (put_en) begin
        chunk_r[{cnt_r[2:0], 3'b000} +: 8] <= put_val;
        cnt_r  <= cnt_r + 4'd1;
        nlen_r <= nlen_r + 8'd1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cur_r    <= CW'(start_offset);
            jumped_r <= 1'b0;
            jumps_r  <= '0;
            next_r   <= '0;
            nlen_r   <= '0;
            chunk_r  <= '0;
            cnt_r    <= '0;
            state_r  <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (!stall) begin
            if (cur_x >= len_x) begin
              stat_r  <= ST_END;
              state_r <= S_FIN;
            end else begin
              state_r <= S_TYPE;
            end
          end
        end
        S_TYPE: begin
          if (!stall) begin
            if (is_ptr) begin
              if (cur1_x >= len_x) begin
                stat_r  <= ST_TRUNC_PTR;
                state_r <= S_FIN;
              end else begin
                hi_r    <= rd_data[5:0];
                state_r <= S_PTR;
              end
            end else if (!is_label) begin
              stat_r  <= ST_BAD_TYPE;
              state_r <= S_FIN;
            end else if (rd_data == 8'd0) begin
              // Root label ends the name
              if (!jumped_r) begin
                next_r <= cur1_x[NEXT_W-1:0];
              end
              stat_r  <= ST_OK;
              state_r <= S_FIN;
            end else if (lbl_end_x > len_x) begin
              stat_r  <= ST_END;
              state_r <= S_FIN;
            end else if (nlen_r != 8'd0 && name_full) begin
              stat_r  <= ST_TOO_LONG;
              state_r <= S_FIN;
            end else begin
              cur_r   <= CW'(cur1_x);
              rem_r   <= rd_data[5:0];
              state_r <= S_LBL;
            end
          end
        end
        S_PTR: begin
          if (!stall) begin
            if (ptr_x >= len_x) begin
              stat_r  <= ST_PTR_OOB;
              state_r <= S_FIN;
            end else begin
              // First pointer fixes the offset after the name
              if (!jumped_r) begin
                next_r <= cur2_x[NEXT_W-1:0];
              end
              jumped_r <= 1'b1;
              cur_r    <= CW'(ptr_x);
              jumps_r  <= jumps_inc;
              if (jumps_x > len_x) begin
                stat_r  <= ST_LOOP;
                state_r <= S_FIN;
              end else begin
                state_r <= S_HEAD;
              end
            end
          end
        end
        S_LBL: begin
          if (!stall) begin
            if (name_full) begin
              stat_r  <= ST_TOO_LONG;
              state_r <= S_FIN;
            end else begin
              cur_r <= CW'(cur1_x);
              rem_r <= rem_r - 6'd1;
              if (rem_r == 6'd1) begin
                state_r <= S_HEAD;
              end
            end
          end
        end
        S_FIN: begin
          if (!stall && out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_name_chunk  = out_chunk_r;
  assign out_chunk_bytes = out_bytes_r;
  assign out_last        = out_last_r;
  assign out_next_offset = out_next_r;
  assign out_status      = out_status_r;

endmodule

FILE: tb/dns_name_decompressor_tb.sv
module dns_name_decompressor_tb;
  import dnd_pkg::*;

  localparam int unsigned PKT_BYTES    = 512;
  localparam int unsigned NAME_LIMIT   = 255;
  localparam int unsigned MAX_CHUNKS   = 32;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Reserved label types
  localparam logic [1:0] TYPE_RSVD_LO = 2'b01;
  localparam logic [1:0] TYPE_RSVD_HI = 2'b10;

  // Shapes of one entry in a random packet
  typedef enum {
    SHAPE_NAME,
    SHAPE_RESERVED,
    SHAPE_LOOP,
    SHAPE_OOB
  } name_shape_t;

  typedef struct {
    logic [63:0]       chunk;
    logic [3:0]        nbytes;
    logic              last;
    logic [NEXT_W-1:0] next_off;
    status_t           status;
  } name_result_t;

  // Mirror of the block: packet store, name walk and expected chunks
  class dns_name_scoreboard;
    logic [7:0]   packet_mirror [PKT_BYTES];
    int unsigned  pkt_len;
    int unsigned  wr_pos;
    bit           load_done;
    logic [63:0]  cur_chunk;
    logic [3:0]   cur_count;
    int unsigned  name_len;
    int unsigned  parse_results;
    name_result_t expected_chunks[$];
    int unsigned  mismatches;

    function new();
      pkt_len    = 0;
      wr_pos     = 0;
      load_done  = 1'b1;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_chunks.size();
    endfunction

    function void push_result(logic [63:0] chunk, logic [3:0] nbytes, logic last,
                              logic [NEXT_W-1:0] next_off, status_t st);
      name_result_t r;
      if (parse_results >= MAX_CHUNKS) return;
      r.chunk    = chunk;
      r.nbytes   = nbytes;
      r.last     = last;
      r.next_off = next_off;
      r.status   = st;
      expected_chunks = {expected_chunks, r};
      parse_results++;
    endfunction

    // Adds one byte of dotted text; a full chunk goes out at once
    function bit append_byte(logic [7:0] c);
      if (name_len >= NAME_LIMIT) return 1'b0;
      cur_chunk[8*cur_count +: 8] = c;
      cur_count++;
      name_len++;
      if (cur_count == CHUNK_BYTES) begin
        push_result(cur_chunk, CHUNK_BYTES, 1'b0, '0, ST_OK);
        cur_chunk = '0;
        cur_count = '0;
      end
      return 1'b1;
    endfunction

    // Walks labels and pointers from start; next_off is set on success
    function status_t walk_name(int unsigned start, output int unsigned next_off);
      int unsigned cursor;
      int unsigned jumps;
      int unsigned ptr;
      int unsigned i;
      bit          jumped;
      logic [7:0]  b;
      cursor   = start;
      jumps    = 0;
      jumped   = 1'b0;
      next_off = 0;
      while (1'b1) begin
        if (cursor >= pkt_len || cursor >= PKT_BYTES) return ST_END;
        b = packet_mirror[cursor];
        if (b[7:6] == TYPE_PTR) begin
          if (cursor + 1 >= pkt_len || cursor + 1 >= PKT_BYTES) return ST_TRUNC_PTR;
          ptr = {b[5:0], packet_mirror[cursor + 1]};
          if (ptr >= pkt_len) return ST_PTR_OOB;
          if (!jumped) begin
            next_off = cursor + 2;
            jumped   = 1'b1;
          end
          cursor = ptr;
          jumps++;
          if (jumps > pkt_len) return ST_LOOP;
          continue;
        end
        if (b[7:6] != TYPE_LABEL) return ST_BAD_TYPE;
        if (b == 8'h00) begin
          if (!jumped) next_off = cursor + 1;
          return ST_OK;
        end
        cursor++;
        if (cursor + b > pkt_len || cursor + b > PKT_BYTES) return ST_END;
        if (name_len > 0 && !append_byte(DOT_CHAR)) return ST_TOO_LONG;
        for (i = 0; i < b; i++) begin
          if (!append_byte(packet_mirror[cursor + i])) return ST_TOO_LONG;
        end
        cursor += b;
      end
      return ST_END;
    endfunction

    // Accepted request: store a byte, or predict the chunks of a parse
    function void note_request(logic op, logic [7:0] pbyte, logic pend, logic [8:0] off);
      status_t     st;
      int unsigned nxt;
      if (op == OP_LOAD) begin
        if (load_done) begin
          wr_pos    = 0;
          pkt_len   = 0;
          load_done = 1'b0;
        end
        if (wr_pos < PKT_BYTES) begin
          packet_mirror[wr_pos] = pbyte;
          wr_pos++;
          pkt_len = wr_pos;
        end
        if (pend) load_done = 1'b1;
      end else begin
        parse_results = 0;
        cur_chunk     = '0;
        cur_count     = '0;
        name_len      = 0;
        st = walk_name(off, nxt);
        // error result carries no text and no offset
        if (st != ST_OK) begin
          cur_chunk = '0;
          cur_count = '0;
          nxt       = 0;
        end
        push_result(cur_chunk, cur_count, 1'b1, NEXT_W'(nxt), st);
      end
    endfunction

    function void check_result(logic [63:0] chunk, logic [3:0] nbytes, logic last,
                               logic [NEXT_W-1:0] next_off, logic [2:0] st);
      name_result_t e;
      if (expected_chunks.size() == 0) begin
        $error("result with nothing expected: name_chunk %h last %0b", chunk, last);
        mismatches++;
        return;
      end
      e = expected_chunks.pop_front();
      if (chunk !== e.chunk) begin
        $error("out_name_chunk: expected %h, got %h", e.chunk, chunk);
        mismatches++;
      end
      if (nbytes !== e.nbytes) begin
        $error("out_chunk_bytes: expected %0d, got %0d", e.nbytes, nbytes);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("out_last: expected %0b, got %0b", e.last, last);
        mismatches++;
      end
      if (next_off !== e.next_off) begin
        $error("out_next_offset: expected %0d, got %0d", e.next_off, next_off);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("out_status: expected %0d, got %0d", e.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_opcode;
  logic [7:0]        in_packet_byte;
  logic              in_packet_end;
  logic [8:0]        in_start_offset;
  logic              out_valid;
  logic              out_ready;
  logic [63:0]       out_name_chunk;
  logic [3:0]        out_chunk_bytes;
  logic              out_last;
  logic [NEXT_W-1:0] out_next_offset;
  logic [2:0]        out_status;

  dns_name_scoreboard sb;
  logic [7:0]         pkt_q[$];
  int unsigned        name_starts[$];
  bit                 in_calm;
  int unsigned        cycle_count;
  int unsigned        probe_offsets[10] = '{0, 1, 6, 8, 10, 11, 12, 14, 16, 18};

  dns_name_decompressor i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_packet_byte  (in_packet_byte),
    .in_packet_end   (in_packet_end),
    .in_start_offset (in_start_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_name_chunk  (out_name_chunk),
    .out_chunk_bytes (out_chunk_bytes),
    .out_last        (out_last),
    .out_next_offset (out_next_offset),
    .out_status      (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor: requests first, so a parse is predicted before its chunks
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_opcode, in_packet_byte, in_packet_end, in_start_offset);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_name_chunk, out_chunk_bytes, out_last, out_next_offset,
                      out_status);
  end

  // Result side: random stall before each result, with calm stretches
  initial begin : result_sink
    int unsigned gap;
    bit          out_calm;
    out_calm  = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One request, after a random gap; returns at the accepting edge
  task automatic send_request(logic op, logic [7:0] pbyte, logic pend, logic [8:0] off);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_opcode       = op;
    in_packet_byte  = pbyte;
    in_packet_end   = pend;
    in_start_offset = off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic parse_at(logic [8:0] off);
    send_request(OP_PARSE, 8'($urandom), 1'($urandom), off);
  endtask

  // Loads pkt_q, end flag on the last byte; optional parses while still open
  task automatic load_packet(bit mid_parse);
    int unsigned i;
    for (i = 0; i < pkt_q.size(); i++) begin
      send_request(OP_LOAD, pkt_q[i], i == pkt_q.size() - 1, 9'($urandom));
      if (mid_parse && i + 1 < pkt_q.size() && $urandom_range(0, 15) == 0)
        parse_at(9'($urandom_range(0, i + 1)));
    end
  endtask

  function automatic void pkt_add(logic [7:0] v);
    pkt_q = {pkt_q, v};
  endfunction

  function automatic void push_label(int unsigned len);
    pkt_add(8'(len));
    repeat (len) pkt_add(8'($urandom));
  endfunction

  function automatic void push_ptr(int unsigned target);
    pkt_add({TYPE_PTR, 6'(target >> 8)});
    pkt_add(8'(target));
  endfunction

  // Mostly well-formed names with back pointers, some broken entries and tails
  function automatic void build_random_packet();
    int unsigned target;
    int unsigned p;
    int unsigned r;
    int unsigned len;
    name_shape_t shape;
    pkt_q.delete();
    name_starts.delete();
    target = $urandom_range(12, 40);
    while (pkt_q.size() < target) begin
      p = pkt_q.size();
      name_starts = {name_starts, p};
      r = $urandom_range(0, 9);
      shape = (r < 7) ? SHAPE_NAME : name_shape_t'(r - 6);
      case (shape)
        SHAPE_NAME: begin
          repeat ($urandom_range(0, 3))
            push_label(($urandom_range(0, 7) == 0) ? $urandom_range(1, 63)
                                                   : $urandom_range(1, 10));
          if (name_starts.size() > 1 && $urandom_range(0, 1) == 1)
            push_ptr(name_starts[$urandom_range(0, name_starts.size() - 2)]);
          else
            pkt_add(8'h00);
        end
        SHAPE_RESERVED: begin
          pkt_add({($urandom_range(0, 1) == 1) ? TYPE_RSVD_LO : TYPE_RSVD_HI,
                   6'($urandom)});
        end
        SHAPE_LOOP: begin
          if ($urandom_range(0, 1) == 1) begin
            push_ptr(p);
          end else begin
            push_ptr(p + 2);
            push_ptr(p);
          end
        end
        default: begin
          // random packets never reach 400 bytes
          push_ptr($urandom_range(400, 16383));
        end
      endcase
    end
    // tail: truncated pointer, or a label cut by the packet end
    r = $urandom_range(0, 3);
    if (r == 0) begin
      p = pkt_q.size();
      name_starts = {name_starts, p};
      pkt_add({TYPE_PTR, 6'($urandom)});
    end else if (r == 1) begin
      p = pkt_q.size();
      name_starts = {name_starts, p};
      len = $urandom_range(20, 63);
      pkt_add(8'(len));
      repeat ($urandom_range(0, len - 1)) pkt_add(8'($urandom));
    end
  endfunction

  initial begin : stimulus
    int unsigned i;
    int unsigned rand_items;
    int unsigned nparse;
    sb              = new();
    in_calm         = 1'b0;
    cycle_count     = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_LOAD;
    in_packet_byte  = '0;
    in_packet_end   = 1'b0;
    in_start_offset = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // parse before any packet: end of packet
    parse_at(9'd0);
    parse_at(9'd511);

    // root, plain label, compressed name, both reserved types, self loop,
    // pointer out of range, label cut by the end, pointer cut by the end
    pkt_q = '{8'h00, 8'h03, 8'h61, 8'h62, 8'h63, 8'h00, 8'h01, 8'h78, 8'hC0, 8'h01,
              8'h40, 8'h80, 8'hC0, 8'h0C, 8'hFF, 8'hFF, 8'h3F, 8'h71, 8'hC1};
    load_packet(1'b0);
    foreach (probe_offsets[k]) parse_at(9'(probe_offsets[k]));

    // too-long names: a 63-byte label pointing back at itself reaches exactly
    // 255 bytes before the next dot fails; a short label in front of it
    // overflows inside a label; the low pointer byte doubles as a root name
    pkt_q.delete();
    push_label(63);
    push_ptr(0);
    push_label(5);
    push_ptr(0);
    load_packet(1'b0);
    parse_at(9'd0);
    parse_at(9'd64);
    parse_at(9'd65);
    parse_at(9'd66);
    parse_at(9'd511);

    // random packets, each probed at name starts and stray offsets
    rand_items = 0;
    while (rand_items < 120) begin
      build_random_packet();
      load_packet(1'b1);
      nparse = $urandom_range(4, 10);
      for (i = 0; i < nparse; i++) begin
        if ($urandom_range(0, 4) == 0)
          parse_at(9'($urandom_range(0, 511)));
        else
          parse_at(9'(name_starts[$urandom_range(0, name_starts.size() - 1)]));
      end
      rand_items += pkt_q.size() + nparse;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
sv/dnd_pkg.sv
sv/dnd_store.sv
sv/dnd_loader.sv
sv/dnd_walker.sv
sv/dns_name_decompressor.sv
tb/dns_name_decompressor_tb.sv
